### sv/dq_pkg.sv
`timescale 1ns / 1ps

package dq_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ENTRY_COUNT_W = 5;

  typedef enum logic [1:0] {
    KIND_PUSH_FRONT = 2'd0,
    KIND_PUSH_BACK  = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_POP_BACK   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } ctrl_state_e;

  typedef struct packed {
    kind_e                     kind;
    logic signed [DATA_W-1:0]  value;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]         popped_value;
    status_e                          status;
    logic [ENTRY_COUNT_W-1:0]         entry_count;
  } out_t;

  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

endpackage

### sv/dq_ctrl.sv
`timescale 1ns / 1ps

module dq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  output logic            done_o,
  output dq_pkg::dp_cmd_t cmd_o
);

  dq_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      dq_pkg::ST_IDLE: begin
        if (start) begin
          state_d = dq_pkg::ST_EXEC;
        end
      end
      dq_pkg::ST_EXEC: state_d = dq_pkg::ST_RESP;
      dq_pkg::ST_RESP: state_d = dq_pkg::ST_IDLE;
      default:         state_d = dq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy       = 1'b1;
    done_o     = 1'b0;
    cmd_o.load = 1'b0;
    cmd_o.exec = 1'b0;
    case (state_q)
      dq_pkg::ST_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      dq_pkg::ST_EXEC: cmd_o.exec = 1'b1;
      dq_pkg::ST_RESP: done_o = 1'b1;
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // one result per transfer, shown in the result state that follows the execute state
  a_done_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 done_o)
    else $error("result strobe missing after accepted transfer");

  a_no_accept_while_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy && !cmd_o.load)
    else $error("transfer taken while result is shown");

  a_exec_before_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> done_o)
    else $error("execute step not followed by result");

endmodule

### sv/dq_datapath.sv
`timescale 1ns / 1ps

module dq_datapath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dq_pkg::dp_cmd_t cmd_i,
  input  dq_pkg::in_t     item_i,
  output dq_pkg::out_t    result_o
);

  logic [dq_pkg::DATA_W-1:0] mem_q [dq_pkg::DEPTH];

  dq_pkg::kind_e              kind_q;
  logic [dq_pkg::DATA_W-1:0]  value_q;
  logic [dq_pkg::IDX_W-1:0]   front_q, front_d;
  logic [dq_pkg::CNT_W-1:0]   count_q, count_d;
  dq_pkg::status_e            status_q, status_d;
  logic                       pop_ok_q, pop_ok_d;
  logic [dq_pkg::DATA_W-1:0]  rd_data_q;

  logic                       is_push, is_full, is_empty;
  logic                       wr_en;
  logic [dq_pkg::IDX_W-1:0]   front_dec, front_inc, back_addr, addr;
  logic [dq_pkg::CNT_W-1:0]   back_off;
  logic [dq_pkg::SUM_W-1:0]   back_sum;

  assign is_push  = (kind_q == dq_pkg::KIND_PUSH_FRONT) || (kind_q == dq_pkg::KIND_PUSH_BACK);
  assign is_full  = (count_q == dq_pkg::CNT_W'(dq_pkg::DEPTH));
  assign is_empty = (count_q == '0);

  // ring wrap without relying on a power-of-two depth
  assign front_dec = (front_q == '0) ? dq_pkg::IDX_W'(dq_pkg::DEPTH - 1)
                                     : front_q - dq_pkg::IDX_W'(1);
  assign front_inc = (front_q == dq_pkg::IDX_W'(dq_pkg::DEPTH - 1)) ? '0
                                     : front_q + dq_pkg::IDX_W'(1);

  assign back_off = (kind_q == dq_pkg::KIND_PUSH_BACK) ? count_q
                                                       : count_q - dq_pkg::CNT_W'(1);
  assign back_sum = dq_pkg::SUM_W'(front_q) + dq_pkg::SUM_W'(back_off);
  assign back_addr = (back_sum >= dq_pkg::SUM_W'(dq_pkg::DEPTH))
                   ? dq_pkg::IDX_W'(back_sum - dq_pkg::SUM_W'(dq_pkg::DEPTH))
                   : dq_pkg::IDX_W'(back_sum);

  always_comb begin
    front_d  = front_q;
    count_d  = count_q;
    status_d = dq_pkg::STATUS_OK;
    pop_ok_d = 1'b0;
    wr_en    = 1'b0;
    addr     = back_addr;
    if (is_push) begin
      if (is_full) begin
        status_d = dq_pkg::STATUS_FULL;
      end else begin
        wr_en   = 1'b1;
        count_d = count_q + dq_pkg::CNT_W'(1);
        if (kind_q == dq_pkg::KIND_PUSH_FRONT) begin
          addr    = front_dec;
          front_d = front_dec;
        end
      end
    end else begin
      if (is_empty) begin
        status_d = dq_pkg::STATUS_EMPTY;
      end else begin
        pop_ok_d = 1'b1;
        count_d  = count_q - dq_pkg::CNT_W'(1);
        if (kind_q == dq_pkg::KIND_POP_FRONT) begin
          addr    = front_q;
          front_d = front_inc;
        end
      end
    end
  end

  // payload capture at the input transfer
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= item_i.kind;
      value_q <= item_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      if (wr_en) begin
        mem_q[addr] <= value_q;
      end
      rd_data_q <= mem_q[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q  <= '0;
      count_q  <= '0;
      status_q <= dq_pkg::STATUS_OK;
      pop_ok_q <= 1'b0;
    end else if (cmd_i.exec) begin
      front_q  <= front_d;
      count_q  <= count_d;
      status_q <= status_d;
      pop_ok_q <= pop_ok_d;
    end
  end

  assign result_o.popped_value = pop_ok_q ? rd_data_q : '0;
  assign result_o.status       = status_q;
  assign result_o.entry_count  = dq_pkg::ENTRY_COUNT_W'(count_q);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= dq_pkg::CNT_W'(dq_pkg::DEPTH))
    else $error("entry count beyond depth");

  a_state_only_on_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.exec |=> $stable(count_q) && $stable(front_q))
    else $error("queue pointers moved outside execute step");

  a_pop_ok_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_ok_q |-> status_q == dq_pkg::STATUS_OK)
    else $error("popped value flagged with error status");

endmodule

### sv/double_ended_queue.sv
`timescale 1ns / 1ps

// double-ended queue of signed 32-bit values held in a 16-entry ring store
// input: cmd_i carries kind (push front, push back, pop front, pop back) and
//   value; a transfer happens on a rising edge with start high and busy low
// output: result_o (popped value, status, entry count) is valid for exactly
//   one cycle while done_o is high; the receiver cannot hold it off
// every transfer gives exactly one result
// sequence: after the transfer edge the controller passes through the execute
//   state and then raises done_o in the result state, so the result transfer is
//   at the edge that ends the result state; busy stays high from the transfer
//   until the result cycle ends, so no new item is taken before the last result
//   is shown; the execute step is one store access with a registered read
// pop on an empty queue returns status empty, value 0; push on a full queue is
//   dropped with status full; pushes always return value 0
// reset (rst_ni low, asynchronous) empties the queue and returns to idle; the
//   store contents are not cleared, no pop returns an entry before it is written
module double_ended_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  output logic         busy,
  input  dq_pkg::in_t  cmd_i,
  output logic         done_o,
  output dq_pkg::out_t result_o
);

  dq_pkg::dp_cmd_t dp_cmd;

  dq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (dp_cmd)
  );

  dq_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (dp_cmd),
    .item_i   (cmd_i),
    .result_o (result_o)
  );

endmodule
